// File: design/lfw_pkg.sv
// ----------------------------------------------------------------------------
// lfw_pkg: shared types and constants for the Life-with-fade block
// State, sweep mode and cell codes, plus the neighbor edge mask bundle.
// ----------------------------------------------------------------------------
package lfw_pkg;

  localparam int GRID_MAX_DEF = 128;
  localparam int SIDE_MIN     = 16;
  localparam int FADE_STEPS   = 4;

  // opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_TOGGLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // display codes
  localparam logic [2:0] DISP_DEAD  = 3'd0;
  localparam logic [2:0] DISP_HATCH = 3'd1;
  localparam logic [2:0] DISP_SURV  = 3'd2;
  localparam logic [2:0] DISP_DYING = 3'd3;

  // config register indexes
  localparam logic REG_GRID_SIZE = 1'b0;
  localparam logic REG_PROPER    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SWEEP, ST_DRAIN, ST_ACC_RD, ST_ACC_WR
  } state_t;

  typedef enum logic [1:0] {
    MODE_GEN, MODE_FADE, MODE_CLR
  } mode_t;

  // which neighbor directions lie inside the active grid
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } edge_mask_t;

endpackage

// File: design/lfw_ram.sv
// ----------------------------------------------------------------------------
// lfw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lfw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/lfw_linebuf.sv
// ----------------------------------------------------------------------------
// lfw_linebuf: two-row line buffer of alive bits and neighbor counter
// Alive bits stream in row-major order; the center cell sits one row and
// one cell behind the newest bit, and its eight neighbors are counted.
// ----------------------------------------------------------------------------
module lfw_linebuf #(
  parameter int ROW = 128
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic                   din,
  input  lfw_pkg::edge_mask_t    edges,
  output logic [3:0]             nbr_cnt,
  output logic                   center
);
  import lfw_pkg::*;

  logic [2*ROW+1:0] line_r;
  logic [7:0]       nb;

  // shift line, newest bit at index 0
  always_ff @(posedge clk) begin
    if (shift_en) begin
      line_r <= {line_r[2*ROW:0], din};
    end
  end

  // neighbor taps masked by grid edges
  always_comb begin
    nb[0] = din            & edges.right & edges.bottom;
    nb[1] = line_r[0]      & edges.bottom;
    nb[2] = line_r[1]      & edges.left  & edges.bottom;
    nb[3] = line_r[ROW-1]  & edges.right;
    nb[4] = line_r[ROW+1]  & edges.left;
    nb[5] = line_r[2*ROW-1] & edges.right & edges.top;
    nb[6] = line_r[2*ROW]  & edges.top;
    nb[7] = line_r[2*ROW+1] & edges.left  & edges.top;
    nbr_cnt = 4'(nb[0]) + 4'(nb[1]) + 4'(nb[2]) + 4'(nb[3])
            + 4'(nb[4]) + 4'(nb[5]) + 4'(nb[6]) + 4'(nb[7]);
  end

  assign center = line_r[ROW];

endmodule

// File: design/life_automaton_with_fade.sv
// ----------------------------------------------------------------------------
// life_automaton_with_fade: bounded Life grid with fading dead cells
// Cell state lives in two RAMs swept by a read-modify-write pipeline.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows as a one-cycle out_valid pulse, which the receiver must take. A
// generation tick sweeps the whole GRID_MAX x GRID_MAX array through a
// two-row line buffer, one cell per cycle. A fade tick or a clear sweeps
// every cell once. After reset a clearing pass runs with busy high; config
// writes still land.
module life_automaton_with_fade #(
  parameter int GRID_MAX = lfw_pkg::GRID_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [6:0] in_cell_x,
  input  logic [6:0] in_cell_y,
  output logic       out_valid,
  output logic       out_cell_alive,
  output logic [2:0] out_display_state,
  output logic       out_was_generation,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import lfw_pkg::*;

  localparam int N  = GRID_MAX * GRID_MAX;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(N + GRID_MAX + 1);
  localparam int XW = $clog2(GRID_MAX);
  localparam int SW = $clog2(GRID_MAX + 1);

  // config registers
  logic [7:0] grid_size_r;
  logic       proper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= 8'd128;
      proper_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SIZE: grid_size_r <= cfg_data;
        REG_PROPER:    proper_r    <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // active side, clamped
  logic [SW-1:0] side_c;
  always_comb begin
    if (grid_size_r < 8'(SIDE_MIN)) begin
      side_c = SW'(SIDE_MIN);
    end else if (32'(grid_size_r) > GRID_MAX) begin
      side_c = SW'(GRID_MAX);
    end else begin
      side_c = SW'(grid_size_r);
    end
  end

  // control registers
  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic          init_r, init_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [XW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic          gen_r, gen_nxt;
  logic          ev_v_r, ev_v_nxt;
  logic          sh_v_r, sh_v_nxt;
  logic          out_valid_r, out_valid_nxt;
  // payload registers
  logic [AW-1:0] ev_addr_r, ev_addr_nxt;
  logic [XW-1:0] ev_cx_r, ev_cx_nxt, ev_cy_r, ev_cy_nxt;
  logic [2:0]    fade_disp_r, fade_disp_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          inside_r, inside_nxt;
  logic [SW-1:0] side_r, side_nxt;
  logic          out_alive_r, out_alive_nxt;
  logic [2:0]    out_disp_r, out_disp_nxt;
  logic          out_gen_r, out_gen_nxt;

  // RAM ports
  logic          a_we, d_we;
  logic [AW-1:0] a_waddr, d_waddr, a_raddr, d_raddr;
  logic          a_wdata, a_rdata;
  logic [3:0]    d_wdata, d_rdata;

  lfw_ram #(.WIDTH(1), .DEPTH(N)) u_alive_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  // display code in [3:1], just-died mark in [0]
  lfw_ram #(.WIDTH(4), .DEPTH(N)) u_disp_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  // neighbor window for the evaluated cell
  edge_mask_t ev_edges;
  logic       ev_inside;
  logic [3:0] nbr_cnt;
  logic       ctr_alive;

  always_comb begin
    ev_edges.left   = (ev_cx_r != '0);
    ev_edges.right  = (SW'(ev_cx_r) + SW'(1)) < side_r;
    ev_edges.top    = (ev_cy_r != '0);
    ev_edges.bottom = (SW'(ev_cy_r) + SW'(1)) < side_r;
    ev_inside       = (SW'(ev_cx_r) < side_r) && (SW'(ev_cy_r) < side_r);
  end

  lfw_linebuf #(.ROW(GRID_MAX)) u_linebuf (
    .clk(clk), .shift_en(sh_v_r), .din(a_rdata), .edges(ev_edges),
    .nbr_cnt(nbr_cnt), .center(ctr_alive)
  );

  // sweep addressing
  logic [CW-1:0] ctr_full;
  logic          ctr_v, sweep_last;
  logic [AW-1:0] ctr_addr;

  always_comb begin
    if (mode_r == MODE_GEN) begin
      ctr_full   = c_r - CW'(GRID_MAX + 1);
      ctr_v      = (c_r >= CW'(GRID_MAX + 1));
      sweep_last = (c_r == CW'(N + GRID_MAX));
    end else begin
      ctr_full   = c_r;
      ctr_v      = 1'b1;
      sweep_last = (c_r == CW'(N - 1));
    end
    ctr_addr = ctr_full[AW-1:0];
  end

  // read addresses
  always_comb begin
    if (state_r == ST_ACC_RD) begin
      a_raddr = idx_r;
      d_raddr = idx_r;
    end else begin
      a_raddr = (c_r < CW'(N)) ? c_r[AW-1:0] : '0;
      d_raddr = ctr_addr;
    end
  end

  // cell update: sweep write-back (generation, fade, clear) and toggle
  logic       gen_alive, gen_mark;
  logic [2:0] gen_disp;

  always_comb begin
    gen_alive = ctr_alive;
    gen_disp  = d_rdata[3:1];
    gen_mark  = 1'b0;
    if (ev_inside) begin
      if (ctr_alive) begin
        if (nbr_cnt == 4'd2 || nbr_cnt == 4'd3) begin
          gen_disp = DISP_SURV;
        end else begin
          gen_alive = 1'b0;
          gen_disp  = DISP_DYING;
          gen_mark  = 1'b1;
        end
      end else if (nbr_cnt == 4'd3) begin
        gen_alive = 1'b1;
        gen_disp  = DISP_HATCH;
      end
    end
  end

  always_comb begin
    a_we    = 1'b0;
    d_we    = 1'b0;
    a_waddr = ev_addr_r;
    d_waddr = ev_addr_r;
    a_wdata = 1'b0;
    d_wdata = '0;
    if (state_r == ST_ACC_WR) begin
      a_waddr = idx_r;
      d_waddr = idx_r;
      a_we    = (op_r == OP_TOGGLE) && inside_r;
      d_we    = a_we;
      a_wdata = !a_rdata;
      d_wdata = {(a_rdata ? DISP_DEAD : DISP_SURV), d_rdata[0]};
    end else if (ev_v_r) begin
      case (mode_r)
        MODE_GEN: begin
          a_we    = 1'b1;
          d_we    = 1'b1;
          a_wdata = gen_alive;
          d_wdata = {gen_disp, gen_mark};
        end
        MODE_FADE: begin
          d_we    = d_rdata[0];
          d_wdata = {fade_disp_r, 1'b1};
        end
        MODE_CLR: begin
          a_we = 1'b1;
          d_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // next state and control
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    init_nxt      = init_r;
    c_nxt         = c_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    phase_nxt     = phase_r;
    gen_nxt       = gen_r;
    ev_v_nxt      = 1'b0;
    sh_v_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    ev_addr_nxt   = ctr_addr;
    ev_cx_nxt     = cx_r;
    ev_cy_nxt     = cy_r;
    fade_disp_nxt = fade_disp_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    inside_nxt    = inside_r;
    side_nxt      = side_r;
    out_alive_nxt = out_alive_r;
    out_disp_nxt  = out_disp_r;
    out_gen_nxt   = out_gen_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt     = in_opcode;
          side_nxt   = side_c;
          inside_nxt = (32'(in_cell_x) < 32'(side_c)) && (32'(in_cell_y) < 32'(side_c));
          idx_nxt    = AW'(32'(in_cell_y) * GRID_MAX + 32'(in_cell_x));
          gen_nxt    = 1'b0;
          c_nxt      = '0;
          cx_nxt     = '0;
          cy_nxt     = '0;
          case (in_opcode)
            OP_TICK: begin
              state_nxt = ST_SWEEP;
              if (!proper_r && phase_r != 3'd0) begin
                mode_nxt      = MODE_FADE;
                fade_disp_nxt = (32'(phase_r) >= FADE_STEPS) ? DISP_DEAD
                                : DISP_DYING + phase_r;
                phase_nxt     = (32'(phase_r) >= FADE_STEPS) ? 3'd0 : phase_r + 3'd1;
              end else begin
                mode_nxt  = MODE_GEN;
                phase_nxt = 3'd1;
                gen_nxt   = 1'b1;
              end
            end
            OP_CLEAR: begin
              state_nxt = ST_SWEEP;
              mode_nxt  = MODE_CLR;
              phase_nxt = 3'd0;
            end
            default: state_nxt = ST_ACC_RD;
          endcase
        end
      end
      ST_SWEEP: begin
        ev_v_nxt = ctr_v;
        sh_v_nxt = (mode_r == MODE_GEN);
        c_nxt    = c_r + CW'(1);
        if (ctr_v) begin
          if (32'(cx_r) == GRID_MAX - 1) begin
            cx_nxt = '0;
            cy_nxt = cy_r + XW'(1);
          end else begin
            cx_nxt = cx_r + XW'(1);
          end
        end
        if (sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (init_r) begin
          init_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ACC_RD;
        end
      end
      ST_ACC_RD: state_nxt = ST_ACC_WR;
      ST_ACC_WR: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_gen_nxt   = gen_r;
        if (!inside_r) begin
          out_alive_nxt = 1'b0;
          out_disp_nxt  = DISP_DEAD;
        end else if (op_r == OP_TOGGLE) begin
          out_alive_nxt = !a_rdata;
          out_disp_nxt  = a_rdata ? DISP_DEAD : DISP_SURV;
        end else begin
          out_alive_nxt = a_rdata;
          out_disp_nxt  = d_rdata[3:1];
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state; reset starts a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      mode_r      <= MODE_CLR;
      init_r      <= 1'b1;
      c_r         <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      phase_r     <= 3'd0;
      gen_r       <= 1'b0;
      ev_v_r      <= 1'b0;
      sh_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      init_r      <= init_nxt;
      c_r         <= c_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      phase_r     <= phase_nxt;
      gen_r       <= gen_nxt;
      ev_v_r      <= ev_v_nxt;
      sh_v_r      <= sh_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ev_addr_r   <= ev_addr_nxt;
    ev_cx_r     <= ev_cx_nxt;
    ev_cy_r     <= ev_cy_nxt;
    fade_disp_r <= fade_disp_nxt;
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    inside_r    <= inside_nxt;
    side_r      <= side_nxt;
    out_alive_r <= out_alive_nxt;
    out_disp_r  <= out_disp_nxt;
    out_gen_r   <= out_gen_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_cell_alive     = out_alive_r;
  assign out_display_state  = out_disp_r;
  assign out_was_generation = out_gen_r;

endmodule
